[rtl/core/chained_hash_map_top_defines.svh]
// Assertion macros for the chained hash map core
`ifndef CHAINED_HASH_MAP_TOP_DEFINES_SVH
`define CHAINED_HASH_MAP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/chm_pkg.sv]
// Shared widths and codes for the chained hash map core
package chm_pkg;

  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 64;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 9;
  localparam int COUNT_W    = 11;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_PUT    = 1'b1;

endpackage

[rtl/core/chm_mod.sv]
// Iterative remainder unit: replicated hash byte modulo the bucket count
module chm_mod #(
  parameter int W = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [chm_pkg::BYTE_W-1:0] fold,
  input  logic [W-1:0]              modulus,
  output logic                      done,
  output logic [W-1:0]              rem
);
  import chm_pkg::*;

  logic [BYTE_W-1:0] fold_q;
  logic [2:0]        cnt;
  logic              busy;
  logic [W-1:0]      rem_next;

  // one byte of the replicated word per cycle, MSB first, one compare-subtract per bit
  always_comb begin
    logic [W:0] t;
    t = '0;
    rem_next = rem;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      t = {rem_next, fold_q[j]};
      if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
      rem_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fold_q <= fold;
      rem    <= '0;
    end else if (busy) begin
      rem <= rem_next;
    end
  end

endmodule

[rtl/core/chained_hash_map_top.sv]
// Chained hash map: sequencer, bucket/entry memories and output register
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser op, tdata key,value
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser found,status; tdata value,count
//  cfg       | in        | cfg_valid/cfg_ready          | cfg_data bucket count
//
// For each operation the remainder unit takes one hash byte per cycle, then raises its
// done flag; each chain node visited is read on the entry memory read port, and a
// remove or insert adds link writes.
// After reset a clearing pass runs over every bucket and entry address; no item is
// accepted meanwhile. A waiting result does not block acceptance of the next item.
module chained_hash_map_top #(
  parameter int ENTRIES = 1024,
  parameter int BUCKETS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [chm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // key[63:0], value[95:64]
  input  logic                           s_axis_tuser,   // operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [chm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // read_value[31:0], count[42:32], 0
  output logic [chm_pkg::OUT_USER_W-1:0] m_axis_tuser,   // found[0], status[1]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [chm_pkg::CFG_W-1:0]      cfg_data
);
  import chm_pkg::*;

  localparam int EW   = $clog2(ENTRIES + 1);
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BCW  = $clog2(BUCKETS + 1);
  localparam int SWEEP = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int SW   = (SWEEP > 1) ? $clog2(SWEEP) : 1;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MOD   = 10'b0000000100,
    S_HEAD  = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_ACT   = 10'b0000100000,
    S_REM2  = 10'b0001000000,
    S_INS   = 10'b0010000000,
    S_INS2  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  logic [EW-1:0]      bucket_head [BUCKETS];
  logic [KEY_W-1:0]   entry_key   [ENTRIES];
  logic [VALUE_W-1:0] entry_value [ENTRIES];
  logic [EW-1:0]      entry_link  [ENTRIES];

  logic [EW-1:0]      head_rd, link_rd;
  logic [KEY_W-1:0]   key_rd;
  logic [VALUE_W-1:0] val_rd;

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic [BW-1:0]      bk_q;
  logic [EW-1:0]      cur, prev, new_n, free_head, total;
  logic               found_q, status_q;
  logic [VALUE_W-1:0] rd_q;
  logic [BCW-1:0]     bc, bc_next;
  logic [SW-1:0]      clr_addr;

  logic               accept;
  logic [BYTE_W-1:0]  fold;
  logic               mod_done;
  logic [BCW-1:0]     mod_rem;
  logic               full;

  logic               head_we, head_re;
  logic [BW-1:0]      head_wa, head_ra;
  logic [EW-1:0]      head_wd;
  logic               link_we, key_we, val_we, ent_re;
  logic [AW-1:0]      link_wa, kv_wa, ent_ra;
  logic [EW-1:0]      link_wd;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign full          = (free_head == NIL) || (total >= NIL);

  always_comb begin
    fold = '0;
    for (int i = 0; i < KEY_W / BYTE_W; i++) fold = fold ^ s_axis_tdata[i*BYTE_W +: BYTE_W];
  end

  chm_mod #(.W(BCW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .fold    (fold),
    .modulus (bc),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // clamp the bucket count into 1..BUCKETS
  always_comb begin
    logic [31:0] v;
    v = 32'(cfg_data);
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(BUCKETS)) v = 32'(BUCKETS);
    bc_next = BCW'(v);
  end

  // memory port control
  always_comb begin
    head_we = 1'b0; head_re = 1'b0;
    head_wa = bk_q; head_ra = mod_rem[BW-1:0]; head_wd = NIL;
    link_we = 1'b0; key_we = 1'b0; val_we = 1'b0; ent_re = 1'b0;
    link_wa = cur[AW-1:0]; kv_wa = cur[AW-1:0]; ent_ra = cur[AW-1:0];
    link_wd = NIL;
    case (state)
      S_CLEAR: begin
        head_we = (32'(clr_addr) < BUCKETS);
        head_wa = clr_addr[BW-1:0];
        link_we = (32'(clr_addr) < ENTRIES);
        link_wa = clr_addr[AW-1:0];
        link_wd = EW'(clr_addr) + EW'(1);
      end
      S_MOD:  head_re = mod_done;
      S_HEAD: begin
        ent_re = (head_rd != NIL);
        ent_ra = head_rd[AW-1:0];
      end
      S_CMP: begin
        ent_re = (key_rd != key_q) && (link_rd != NIL);
        ent_ra = link_rd[AW-1:0];
      end
      S_ACT: begin
        if (op_q == OP_PUT && found_q) begin
          if (val_q != '0) begin
            val_we = 1'b1;
          end else if (prev == NIL) begin
            head_we = 1'b1;
            head_wd = link_rd;
          end else begin
            link_we = 1'b1;
            link_wa = prev[AW-1:0];
            link_wd = link_rd;
          end
        end else if (op_q == OP_PUT && val_q != '0 && !full) begin
          ent_re = 1'b1;
          ent_ra = free_head[AW-1:0];
        end
      end
      S_REM2: begin
        link_we = 1'b1;
        link_wd = free_head;
      end
      S_INS: begin
        key_we  = 1'b1;
        val_we  = 1'b1;
        kv_wa   = free_head[AW-1:0];
        link_we = 1'b1;
        link_wa = free_head[AW-1:0];
        head_we = (prev == NIL);
        head_wd = free_head;
      end
      S_INS2: begin
        link_we = 1'b1;
        link_wa = prev[AW-1:0];
        link_wd = new_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) bucket_head[head_wa] <= head_wd;
    if (head_re) head_rd <= bucket_head[head_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) entry_link[link_wa] <= link_wd;
    if (key_we)  entry_key[kv_wa]    <= key_q;
    if (val_we)  entry_value[kv_wa]  <= val_q;
    if (ent_re) begin
      link_rd <= entry_link[ent_ra];
      key_rd  <= entry_key[ent_ra];
      val_rd  <= entry_value[ent_ra];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      free_head     <= '0;
      total         <= '0;
      bc            <= BCW'(BUCKETS);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && total == '0) bc <= bc_next;
      // S_DONE drives the valid flag itself
      if (m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SW'(1);
          if (32'(clr_addr) == SWEEP - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= s_axis_tuser;
            key_q    <= s_axis_tdata[KEY_W-1:0];
            val_q    <= s_axis_tdata[KEY_W +: VALUE_W];
            found_q  <= 1'b0;
            status_q <= 1'b0;
            rd_q     <= '0;
            prev     <= NIL;
            state    <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bk_q  <= mod_rem[BW-1:0];
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur   <= head_rd;
          state <= (head_rd == NIL) ? S_ACT : S_CMP;
        end
        S_CMP: begin
          if (key_rd == key_q) begin
            found_q <= 1'b1;
            state   <= S_ACT;
          end else begin
            // advance along the chain
            prev <= cur;
            cur  <= link_rd;
            if (link_rd == NIL) state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_DONE;
          if (op_q == OP_LOOKUP) begin
            if (found_q) rd_q <= val_rd;
          end else if (found_q) begin
            if (val_q == '0) state <= S_REM2;
          end else if (val_q != '0) begin
            if (full) status_q <= 1'b1;
            else state <= S_INS;
          end
        end
        S_REM2: begin
          free_head <= cur;
          if (total != '0) total <= total - EW'(1);
          state <= S_DONE;
        end
        S_INS: begin
          new_n     <= free_head;
          free_head <= link_rd;
          total     <= total + EW'(1);
          state     <= (prev == NIL) ? S_DONE : S_INS2;
        end
        S_INS2: state <= S_DONE;
        S_DONE: begin
          // hold until the output register frees up
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= {status_q, found_q};
            m_axis_tdata  <= {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), COUNT_W'(total), rd_q};
            state         <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`include "chained_hash_map_top_defines.svh"

  `CHM_ASSERT_NOW(a_total_bound, 1'b1, total <= NIL, "entry count above pool size")
  `CHM_ASSERT_NOW(a_free_empty, free_head == NIL, total == NIL, "free list empty with room left")
  `CHM_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready, "ready held after accept")
  `CHM_ASSERT_NOW(a_mod_in_state, mod_done, state == S_MOD, "remainder done outside hash step")

endmodule
